>>> hw/rtl/cpc_pkg.sv
// Shared types, constants and helper functions of the cartesian/polar CORDIC unit.
package cpc_pkg;

   localparam logic [1:0] OP_RADIUS = 2'd1;
   localparam logic [1:0] OP_ANGLE  = 2'd2;

   localparam int GUARD      = 8;
   localparam int VW         = 44;
   localparam int ZW         = 36;
   localparam int RW         = 46;
   localparam int AMPW       = 35;
   localparam int PW         = 66;
   localparam int RMW        = 36;
   localparam int SQRT_STEPS = 32;

   localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [30:0]   KINV_Q30    = 31'sd652032874;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic [63:0]     rad;
      logic [31:0]     root;
      logic [RMW-1:0]  rem;
   } sqrt_type;

   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] v;
      unique case (idx)
         0:  v = 30'd843314857;
         1:  v = 30'd497837829;
         2:  v = 30'd263043837;
         3:  v = 30'd133525159;
         4:  v = 30'd67021687;
         5:  v = 30'd33543516;
         6:  v = 30'd16775851;
         7:  v = 30'd8388437;
         8:  v = 30'd4194283;
         9:  v = 30'd2097149;
         10: v = 30'd1048576;
         11: v = 30'd524288;
         12: v = 30'd262144;
         13: v = 30'd131072;
         14: v = 30'd65536;
         15: v = 30'd32768;
         16: v = 30'd16384;
         17: v = 30'd8192;
         18: v = 30'd4096;
         19: v = 30'd2048;
         20: v = 30'd1024;
         21: v = 30'd512;
         22: v = 30'd256;
         23: v = 30'd128;
         24: v = 30'd64;
         25: v = 30'd32;
         26: v = 30'd16;
         27: v = 30'd8;
         28: v = 30'd4;
         29: v = 30'd2;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   // Fold the point into the right half plane and add guard bits.
   function automatic vec_type vec_prep(input logic signed [31:0] px,
                                        input logic signed [31:0] py);
      logic signed [32:0] ax;
      logic signed [32:0] ay;
      vec_type v;
      ax = {px[31], px};
      ay = {py[31], py};
      if (px[31]) begin
         ax = -ax;
         ay = -ay;
      end
      v.x = {{(VW-33-GUARD){ax[32]}}, ax, {GUARD{1'b0}}};
      v.y = {{(VW-33-GUARD){ay[32]}}, ay, {GUARD{1'b0}}};
      v.z = '0;
      return v;
   endfunction

   function automatic logic signed [ZW-1:0] vec_finish(input logic signed [ZW-1:0] z,
                                                       input logic neg,
                                                       input logic zero);
      logic signed [ZW-1:0] r;
      if (zero) begin
         r = '0;
      end else if (neg) begin
         r = z + PI_Q30;
      end else begin
         r = z;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/cpc_vec_cell.sv
// One vectoring CORDIC micro-rotation cell.
module cpc_vec_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  cpc_pkg::vec_type d,
   output cpc_pkg::vec_type q
);
   import cpc_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = {{(ZW-30){1'b0}}, atan_q30(STEP)};

   vec_type out_ff;
   vec_type out_in;

   always_comb begin
      out_in = d;
      // drive y toward zero
      if (!d.y[VW-1]) begin
         out_in.x = d.x + ($signed(d.y) >>> STEP);
         out_in.y = d.y - ($signed(d.x) >>> STEP);
         out_in.z = d.z + ATAN;
      end else begin
         out_in.x = d.x - ($signed(d.y) >>> STEP);
         out_in.y = d.y + ($signed(d.x) >>> STEP);
         out_in.z = d.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign q = out_ff;
endmodule

>>> hw/rtl/cpc_rot_cell.sv
// One rotation-mode CORDIC micro-rotation cell.
module cpc_rot_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  cpc_pkg::rot_type d,
   output cpc_pkg::rot_type q
);
   import cpc_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = {{(ZW-30){1'b0}}, atan_q30(STEP)};

   rot_type out_ff;
   rot_type out_in;

   always_comb begin
      out_in = d;
      // drive residual angle toward zero
      if (!d.z[ZW-1]) begin
         out_in.x = d.x - ($signed(d.y) >>> STEP);
         out_in.y = d.y + ($signed(d.x) >>> STEP);
         out_in.z = d.z - ATAN;
      end else begin
         out_in.x = d.x + ($signed(d.y) >>> STEP);
         out_in.y = d.y - ($signed(d.x) >>> STEP);
         out_in.z = d.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign q = out_ff;
endmodule

>>> hw/rtl/cpc_sqrt_cell.sv
// One restoring square-root cell: settles one root bit per stage.
module cpc_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  cpc_pkg::sqrt_type d,
   output cpc_pkg::sqrt_type q
);
   import cpc_pkg::*;

   sqrt_type        out_ff;
   sqrt_type        out_in;
   logic [RMW-1:0]  shifted;
   logic [RMW-1:0]  trial;

   always_comb begin
      shifted    = {d.rem[RMW-3:0], d.rad[63:62]};
      trial      = {{(RMW-34){1'b0}}, d.root, 2'b01};
      out_in.rad = {d.rad[61:0], 2'b00};
      if (shifted >= trial) begin
         out_in.rem  = shifted - trial;
         out_in.root = {d.root[30:0], 1'b1};
      end else begin
         out_in.rem  = shifted;
         out_in.root = {d.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign q = out_ff;
endmodule

>>> hw/rtl/cpc_delay.sv
// Enabled shift line that keeps side data aligned with the cell chains.
module cpc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   generate
      if (DEPTH == 0) begin : g_none
         assign q = d;
      end else begin : g_line
         logic [WIDTH-1:0] line_ff [DEPTH];
         always_ff @(posedge clock) begin
            if (en) begin
               line_ff[0] <= d;
               for (int i = 1; i < DEPTH; i++) begin
                  line_ff[i] <= line_ff[i-1];
               end
            end
         end
         assign q = line_ff[DEPTH-1];
      end
   endgenerate
endmodule

>>> hw/rtl/cartesian_polar_cordic_unit_top.sv
// Cartesian/polar CORDIC unit: fully pipelined, one beat accepted per clock. The front
// end measures the input point (vectoring cells, a 32-cell square-root row) and reduces
// the angle operand modulo 2*pi (a row of compare-subtract cells); a rotation row then
// places the new point; a second vectoring row and square-root row measure the saturated
// result. The whole pipe advances together and holds only while the result register is
// full and stalled, so the rate is one item per cycle whenever the result side keeps
// taking beats.
module cartesian_polar_cordic_unit_top #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_x_in,
   input  logic signed [31:0] req_y_in,
   input  logic signed [33:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic [31:0]        rsp_radius,
   output logic signed [19:0] rsp_angle,
   output logic               rsp_saturated
);
   import cpc_pkg::*;

   localparam int S         = CORDIC_STEPS;
   localparam int FRONT     = 34;
   localparam int MOD_STEPS = 31 - FRAC_BITS;
   localparam int MW        = 64 - FRAC_BITS;
   localparam int ASH       = 30 - FRAC_BITS;
   localparam int PT        = 38 + S;
   localparam int TOTAL     = PT + 35;

   function automatic logic [32:0] clip32(input logic signed [RW-1:0] v);
      logic [32:0] r;
      if (v[RW-1:31] == {(RW-31){v[RW-1]}}) begin
         r = {1'b0, v[31:0]};
      end else begin
         r = {1'b1, (v[RW-1] ? 32'h8000_0000 : 32'h7fff_ffff)};
      end
      return r;
   endfunction

   // ---------------- pipe control ----------------
   logic             en;
   logic [TOTAL-1:0] vld_ff;
   logic [TOTAL-1:0] vld_in;

   assign en        = !(vld_ff[TOTAL-1] && rsp_stall);
   assign req_stall = !en;
   assign vld_in    = {vld_ff[TOTAL-2:0], req_valid};
   assign rsp_valid = vld_ff[TOTAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- front: angle of input point ----------------
   vec_type              fv [S+1];
   logic [1:0]           fflag_d;
   logic [1:0]           fflag_q;
   logic signed [ZW-1:0] fa_ff;
   logic signed [ZW-1:0] fa_in;
   logic [ZW-1:0]        fa_q;

   assign fv[0]   = vec_prep(req_x_in, req_y_in);
   assign fflag_d = {req_x_in[31], (req_x_in == '0) && (req_y_in == '0)};

   generate
      for (genvar k = 0; k < S; k++) begin : g_fvec
         cpc_vec_cell #(.STEP(k)) u_cell (.clock(clock), .en(en), .d(fv[k]), .q(fv[k+1]));
      end
   endgenerate

   cpc_delay #(.WIDTH(2), .DEPTH(S)) u_fflag (
      .clock(clock), .en(en), .d(fflag_d), .q(fflag_q));

   assign fa_in = vec_finish(fv[S].z, fflag_q[1], fflag_q[0]);

   always_ff @(posedge clock) begin
      if (en) begin
         fa_ff <= fa_in;
      end
   end

   cpc_delay #(.WIDTH(ZW), .DEPTH(FRONT - 1 - S)) u_fa (
      .clock(clock), .en(en), .d(fa_ff), .q(fa_q));

   // ---------------- front: radius of input point ----------------
   logic [63:0] fsa_ff, fsa_in, fsb_ff, fsb_in, fsum_ff, fsum_in;
   sqrt_type    fs [SQRT_STEPS+1];

   assign fsa_in  = abs32(req_x_in) * abs32(req_x_in);
   assign fsb_in  = abs32(req_y_in) * abs32(req_y_in);
   assign fsum_in = fsa_ff + fsb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fsa_ff  <= fsa_in;
         fsb_ff  <= fsb_in;
         fsum_ff <= fsum_in;
      end
   end

   assign fs[0] = '{rad: fsum_ff, root: '0, rem: '0};

   generate
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_fsqrt
         cpc_sqrt_cell u_cell (.clock(clock), .en(en), .d(fs[k]), .q(fs[k+1]));
      end
   endgenerate

   // ---------------- front: operand angle modulo 2*pi ----------------
   logic signed [MW-1:0]   mod_z;
   logic [MW-1:0]          mod_src0;
   logic [MW-1:0]          mod_mag_ff [MOD_STEPS];
   logic [MW-1:0]          mod_mag_in [MOD_STEPS];
   logic [MOD_STEPS-1:0]   mod_neg_ff;
   logic [MOD_STEPS-1:0]   mod_neg_in;
   logic [33:0]            fmod_d;
   logic [33:0]            fmod_q;

   assign mod_z      = {req_operand, {ASH{1'b0}}};
   assign mod_src0   = req_operand[33] ? MW'(-mod_z) : MW'(mod_z);
   assign mod_neg_in = {mod_neg_ff[MOD_STEPS-2:0], req_operand[33]};

   generate
      for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
         localparam logic [MW-1:0] SUB = MW'(TWO_PI_Q30) << (MOD_STEPS - 1 - k);
         logic [MW-1:0] src;
         if (k == 0) begin : g_first
            assign src = mod_src0;
         end else begin : g_next
            assign src = mod_mag_ff[k-1];
         end
         assign mod_mag_in[k] = (src >= SUB) ? (src - SUB) : src;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         mod_neg_ff <= mod_neg_in;
         for (int k = 0; k < MOD_STEPS; k++) begin
            mod_mag_ff[k] <= mod_mag_in[k];
         end
      end
   end

   assign fmod_d = {mod_neg_ff[MOD_STEPS-1], mod_mag_ff[MOD_STEPS-1][32:0]};

   cpc_delay #(.WIDTH(34), .DEPTH(FRONT - MOD_STEPS)) u_fmod (
      .clock(clock), .en(en), .d(fmod_d), .q(fmod_q));

   // ---------------- front: side data ----------------
   logic [99:0]        fside_q;
   logic [1:0]         fop;
   logic signed [31:0] fx;
   logic signed [31:0] fy;
   logic signed [33:0] fopd;

   cpc_delay #(.WIDTH(100), .DEPTH(FRONT)) u_fside (
      .clock(clock), .en(en), .d({req_opcode, req_x_in, req_y_in, req_operand}),
      .q(fside_q));

   assign {fop, fx, fy, fopd} = fside_q;

   // ---------------- mid: amplitude and angle selection ----------------
   logic [32:0]             fr;
   logic signed [ZW-1:0]    fmod_e;
   logic signed [ZW-1:0]    fmod_s;
   logic [1:0]              op35_ff, op36_ff, op37_ff;
   logic signed [31:0]      x35_ff, y35_ff, x36_ff, y36_ff, x37_ff, y37_ff;
   logic signed [AMPW-1:0]  amp35_ff, amp35_in;
   logic signed [ZW-1:0]    z35_ff, z35_in, z36_ff, z36_in, z37_ff, z37_in;
   logic signed [PW-1:0]    prod36_ff, prod36_in, prod37_ff;
   logic                    flip37_ff, flip37_in;

   assign fr = 33'(fs[SQRT_STEPS].root)
             + 33'(fs[SQRT_STEPS].rem > RMW'(fs[SQRT_STEPS].root));
   assign fmod_e = {{(ZW-33){1'b0}}, fmod_q[32:0]};
   assign fmod_s = fmod_q[33] ? -fmod_e : fmod_e;

   assign amp35_in = (fop == OP_RADIUS) ? {fopd[33], fopd} : {2'b00, fr};
   assign z35_in   = (fop == OP_RADIUS) ? $signed(fa_q) : fmod_s;

   assign prod36_in = amp35_ff * KINV_Q30;

   always_comb begin
      priority if (z35_ff > PI_Q30) begin
         z36_in = z35_ff - TWO_PI_Q30;
      end else if (z35_ff < -PI_Q30) begin
         z36_in = z35_ff + TWO_PI_Q30;
      end else begin
         z36_in = z35_ff;
      end
   end

   // fold into the right half plane, flip the result back
   always_comb begin
      priority if (z36_ff > HALF_PI_Q30) begin
         z37_in    = z36_ff - PI_Q30;
         flip37_in = 1'b1;
      end else if (z36_ff < -HALF_PI_Q30) begin
         z37_in    = z36_ff + PI_Q30;
         flip37_in = 1'b1;
      end else begin
         z37_in    = z36_ff;
         flip37_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op35_ff   <= fop;
         x35_ff    <= fx;
         y35_ff    <= fy;
         amp35_ff  <= amp35_in;
         z35_ff    <= z35_in;
         op36_ff   <= op35_ff;
         x36_ff    <= x35_ff;
         y36_ff    <= y35_ff;
         prod36_ff <= prod36_in;
         z36_ff    <= z36_in;
         op37_ff   <= op36_ff;
         x37_ff    <= x36_ff;
         y37_ff    <= y36_ff;
         prod37_ff <= prod36_ff;
         z37_ff    <= z37_in;
         flip37_ff <= flip37_in;
      end
   end

   // ---------------- rotation row ----------------
   rot_type      rv [S+1];
   logic [66:0]  rside_q;
   logic [1:0]   rop;
   logic [31:0]  rx;
   logic [31:0]  ry;
   logic         rflip;

   assign rv[0].x = {{(RW-44){prod37_ff[PW-1]}}, prod37_ff[PW-1:30-GUARD]};
   assign rv[0].y = '0;
   assign rv[0].z = z37_ff;

   generate
      for (genvar k = 0; k < S; k++) begin : g_rot
         cpc_rot_cell #(.STEP(k)) u_cell (.clock(clock), .en(en), .d(rv[k]), .q(rv[k+1]));
      end
   endgenerate

   cpc_delay #(.WIDTH(67), .DEPTH(S)) u_rside (
      .clock(clock), .en(en), .d({op37_ff, x37_ff, y37_ff, flip37_ff}), .q(rside_q));

   assign {rop, rx, ry, rflip} = rside_q;

   // ---------------- result point ----------------
   logic signed [RW-1:0] xr, yr, xf, yf;
   logic [32:0]          xc, yc;
   logic signed [31:0]   pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic                 pt_sat_ff, pt_sat_in;

   assign xr = ($signed(rv[S].x) + (RW'(1) << (GUARD - 1))) >>> GUARD;
   assign yr = ($signed(rv[S].y) + (RW'(1) << (GUARD - 1))) >>> GUARD;
   assign xf = rflip ? -xr : xr;
   assign yf = rflip ? -yr : yr;
   assign xc = clip32(xf);
   assign yc = clip32(yf);

   always_comb begin
      if (rop == OP_RADIUS || rop == OP_ANGLE) begin
         pt_x_in   = xc[31:0];
         pt_y_in   = yc[31:0];
         pt_sat_in = xc[32] | yc[32];
      end else begin
         pt_x_in   = rx;
         pt_y_in   = ry;
         pt_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_x_ff   <= pt_x_in;
         pt_y_ff   <= pt_y_in;
         pt_sat_ff <= pt_sat_in;
      end
   end

   // ---------------- back: angle of result point ----------------
   vec_type              bv [S+1];
   logic [1:0]           bflag_d;
   logic [1:0]           bflag_q;
   logic signed [ZW-1:0] ba_ff, ba_in, ba_rnd;
   logic [19:0]          ba2_ff, ba2_in, ba2_q;

   assign bv[0]   = vec_prep(pt_x_ff, pt_y_ff);
   assign bflag_d = {pt_x_ff[31], (pt_x_ff == '0) && (pt_y_ff == '0)};

   generate
      for (genvar k = 0; k < S; k++) begin : g_bvec
         cpc_vec_cell #(.STEP(k)) u_cell (.clock(clock), .en(en), .d(bv[k]), .q(bv[k+1]));
      end
   endgenerate

   cpc_delay #(.WIDTH(2), .DEPTH(S)) u_bflag (
      .clock(clock), .en(en), .d(bflag_d), .q(bflag_q));

   assign ba_in  = vec_finish(bv[S].z, bflag_q[1], bflag_q[0]);
   assign ba_rnd = (ba_ff + (ZW'(1) << (ASH - 1))) >>> ASH;
   assign ba2_in = ba_rnd[19:0];

   always_ff @(posedge clock) begin
      if (en) begin
         ba_ff  <= ba_in;
         ba2_ff <= ba2_in;
      end
   end

   cpc_delay #(.WIDTH(20), .DEPTH(32 - S)) u_ba (
      .clock(clock), .en(en), .d(ba2_ff), .q(ba2_q));

   // ---------------- back: radius of result point ----------------
   logic [63:0] bsa_ff, bsa_in, bsb_ff, bsb_in, bsum_ff, bsum_in;
   sqrt_type    bs [SQRT_STEPS+1];
   logic [32:0] br;

   assign bsa_in  = abs32(pt_x_ff) * abs32(pt_x_ff);
   assign bsb_in  = abs32(pt_y_ff) * abs32(pt_y_ff);
   assign bsum_in = bsa_ff + bsb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         bsa_ff  <= bsa_in;
         bsb_ff  <= bsb_in;
         bsum_ff <= bsum_in;
      end
   end

   assign bs[0] = '{rad: bsum_ff, root: '0, rem: '0};

   generate
      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bsqrt
         cpc_sqrt_cell u_cell (.clock(clock), .en(en), .d(bs[k]), .q(bs[k+1]));
      end
   endgenerate

   assign br = 33'(bs[SQRT_STEPS].root)
             + 33'(bs[SQRT_STEPS].rem > RMW'(bs[SQRT_STEPS].root));

   // ---------------- back: side data and result register ----------------
   logic [64:0]        bside_q;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [31:0]        rsp_radius_ff;
   logic [19:0]        rsp_angle_ff;
   logic               rsp_sat_ff;

   cpc_delay #(.WIDTH(65), .DEPTH(FRONT)) u_bside (
      .clock(clock), .en(en), .d({pt_x_ff, pt_y_ff, pt_sat_ff}), .q(bside_q));

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff      <= bside_q[64:33];
         rsp_y_ff      <= bside_q[32:1];
         rsp_sat_ff    <= bside_q[0];
         rsp_radius_ff <= br[31:0];
         rsp_angle_ff  <= ba2_q;
      end
   end

   assign rsp_x_out     = rsp_x_ff;
   assign rsp_y_out     = rsp_y_ff;
   assign rsp_radius    = rsp_radius_ff;
   assign rsp_angle     = rsp_angle_ff;
   assign rsp_saturated = rsp_sat_ff;
endmodule
